// ===== hdl/fmcs_pkg.sv =====
// Package: request/result types, kind and state codes, hash constants and a multiply helper for the FM sketch.
package fmcs_pkg;

  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432e4f437f;
  localparam logic [63:0] FMIX1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_SEED   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [4:0]  seed_row;
    logic [31:0] seed_value;
  } req_t;

  typedef struct packed {
    logic [1:0] done_kind;
    logic [9:0] rank_sum;
    logic       any_row_full;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // 64x64 low product split into 32x32 partial products
  function automatic logic [63:0] mul_lo(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
    ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh = a[31:0] * b[63:32];
    hl = a[63:32] * b[31:0];
    return ll + {lh + hl, 32'd0};
  endfunction

endpackage

// ===== hdl/fm_cardinality_sketch_top.sv =====
// Top level: FM distinct-count sketch with row memories and a pipelined hash.
//
//  channel | ports                          | moves
//  in      | in_valid, in_stall, in_data    | one request (req_t)
//  out     | out_valid, out_stall, out_data | one result per request (res_t)
//
// Insert, clear and query: once the request is taken, ST_RUN issues ROWS
// rows, one row per cycle through the one row memory port, then ST_DRAIN
// empties the hash pipeline, then ST_DONE registers the result.
// Seed write: ST_IDLE goes straight to ST_DONE, which writes the seed and the result.
// After reset a clearing pass (ST_INIT) zeroes both memories; no request
// is taken meanwhile.
// A waiting result holds in out_data while out_stall is high; the next
// request is taken only after the result leaves.
module fm_cardinality_sketch_top
  import fmcs_pkg::*;
#(
  parameter int ROWS  = 32,
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(ROWS + 1);
  localparam int DEPTH = 12;  // hash pipeline stages before write-back
  localparam int TW = $clog2(WIDTH);

  logic [WIDTH-1:0] rows_mem [ROWS];
  logic [31:0]      seed_mem [ROWS];

  state_t state_r, state_nxt;
  req_t   req_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [4:0] drain_r, drain_nxt;
  logic [10:0] sum_r;
  logic full_r;
  res_t out_r;
  logic out_valid_r;

  // issue stage
  logic issue;
  logic [RW-1:0] issue_row;
  assign issue = (state_r == ST_RUN);
  assign issue_row = cnt_r[RW-1:0];
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;

  // state machine
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_INIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid && !in_stall) begin
          state_nxt = (in_data.kind == KIND_SEED) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        drain_nxt = '0;
        if (cnt_r == CW'(ROWS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == 5'(DEPTH + 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && !in_stall) begin
      req_r <= in_data;
    end
  end

  // seed memory: clearing pass, seed writes, per-row reads
  logic [31:0] seed_rd_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_INIT) begin
      seed_mem[cnt_r[RW-1:0]] <= '0;
    end else if (state_r == ST_DONE && req_r.kind == KIND_SEED &&
                 {27'd0, req_r.seed_row} < 32'(ROWS)) begin
      seed_mem[RW'(req_r.seed_row)] <= req_r.seed_value;
    end
    seed_rd_r <= seed_mem[issue_row];
  end

  // hash pipeline; stage 1 takes the seed from memory
  logic [DEPTH:0] v_p;
  logic [RW-1:0]  row_p [DEPTH+1];
  logic [63:0]    a_p   [DEPTH+1];
  logic [63:0]    b_p   [DEPTH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p <= '0;
    end else begin
      v_p <= {v_p[DEPTH-1:0], issue && (req_r.kind == KIND_INSERT)};
    end
  end

  always_ff @(posedge clk) begin
    row_p[0] <= issue_row;
    for (int i = 1; i <= DEPTH; i++) begin
      row_p[i] <= row_p[i-1];
    end
  end

  always_ff @(posedge clk) begin
    // s0: k1 * C1 (key constant per request)
    a_p[0] <= mul_lo(req_r.key, MM_C1);
    b_p[0] <= '0;
    // s1: rotate, * C2; seed arrives
    a_p[1] <= mul_lo({a_p[0][32:0], a_p[0][63:33]}, MM_C2);
    b_p[1] <= {32'd0, seed_rd_r};
    // s2: h1 ^= k1 ^ 8; h2 = seed ^ 8; h1 += h2
    a_p[2] <= ((b_p[1] ^ a_p[1]) ^ 64'd8) + (b_p[1] ^ 64'd8);
    b_p[2] <= b_p[1] ^ 64'd8;
    // s3: h2 += h1
    a_p[3] <= a_p[2];
    b_p[3] <= b_p[2] + a_p[2];
    // s4..s6: fmix both lanes
    a_p[4] <= mul_lo(a_p[3] ^ (a_p[3] >> 33), FMIX1);
    b_p[4] <= mul_lo(b_p[3] ^ (b_p[3] >> 33), FMIX1);
    a_p[5] <= mul_lo(a_p[4] ^ (a_p[4] >> 33), FMIX2);
    b_p[5] <= mul_lo(b_p[4] ^ (b_p[4] >> 33), FMIX2);
    a_p[6] <= a_p[5] ^ (a_p[5] >> 33);
    b_p[6] <= b_p[5] ^ (b_p[5] >> 33);
    // s7: h1 += h2; s8: h2 += h1
    a_p[7] <= a_p[6] + b_p[6];
    b_p[7] <= b_p[6];
    a_p[8] <= a_p[7];
    b_p[8] <= b_p[7] + a_p[7];
    for (int i = 9; i <= DEPTH; i++) begin
      a_p[i] <= a_p[i-1];
      b_p[i] <= b_p[i-1];
    end
  end

  // capped trailing-zero count on the hash result, registered
  logic [TW-1:0] tz_r;
  logic [TW-1:0] tz_c;
  always_comb begin
    tz_c = TW'(WIDTH - 1);
    for (int i = WIDTH - 2; i >= 0; i--) begin
      if (b_p[DEPTH-1][i]) begin
        tz_c = TW'(i);
      end
    end
  end
  always_ff @(posedge clk) begin
    tz_r <= tz_c;
  end

  // row memory: read at stage DEPTH-1 so data meets tz at DEPTH; rows
  // are distinct within one request so no forwarding is needed
  logic [WIDTH-1:0] row_rd_r;
  logic [RW-1:0] rd_addr;
  logic q_v_r;
  assign rd_addr = (req_r.kind == KIND_INSERT) ? row_p[DEPTH-1] : issue_row;

  always_ff @(posedge clk) begin
    row_rd_r <= rows_mem[rd_addr];
    if (state_r == ST_INIT) begin
      rows_mem[cnt_r[RW-1:0]] <= '0;
    end else if (issue && req_r.kind == KIND_CLEAR) begin
      rows_mem[issue_row] <= '0;
    end else if (v_p[DEPTH]) begin
      rows_mem[row_p[DEPTH]] <= row_rd_r | (WIDTH'(1) << tz_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else begin
      q_v_r <= issue && (req_r.kind == KIND_QUERY);
    end
  end

  // query: first zero index of each row, accumulated
  logic [TW-1:0] fz_c;
  always_comb begin
    fz_c = TW'(WIDTH - 1);
    for (int j = WIDTH - 1; j >= 0; j--) begin
      if (!row_rd_r[j]) begin
        fz_c = TW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      sum_r  <= '0;
      full_r <= 1'b0;
    end else if (q_v_r) begin
      sum_r  <= (sum_r + 11'(fz_c) > 11'd1023) ? 11'd1023 : sum_r + 11'(fz_c);
      full_r <= full_r | (&row_rd_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_r.done_kind    <= req_r.kind;
      out_r.rank_sum     <= (req_r.kind == KIND_QUERY) ? sum_r[9:0] : 10'd0;
      out_r.any_row_full <= (req_r.kind == KIND_QUERY) ? full_r : 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
